// File: hw/rtl/pfd_pkg.sv
// shared constants for the parity frame deframer
`timescale 1ns / 1ps

package pfd_pkg;

  localparam int FRAME_BYTES = 64;
  localparam int BYTE_W      = 8;
  localparam int CHAR_W      = 7;
  localparam int LEN_W       = 7;
  localparam int CNT_W       = 24;

  localparam logic [LEN_W-1:0] FRAME_LEN = LEN_W'(FRAME_BYTES);
  localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};

endpackage

// File: hw/rtl/parity_frame_deframer.sv
// parity frame deframer: header parsing, odd parity check and stream counters
//
// Input channel (rx_valid, rx_stall, rx_byte) carries one received byte per
// transfer. Each frame is three header bytes, the third being the payload
// length (clamped to FRAME_BYTES), then that many payload bytes.
// Result channel (res_valid, res_stall and the result fields) gives one
// result per payload byte: the character with bit 7 cleared, a flag for even
// parity, the byte offset in the stream and the running error total.
// A frame shorter than FRAME_BYTES ends the stream: its last result carries
// stream_end, after which the offset and error counters restart at zero.
// A zero length header gives a single result with has_data low and
// stream_end high. Other header bytes give no result.
// A byte taken passes through the input register, then the result register.
// Throughput is one byte per cycle; the byte in the input register moves on
// whenever the result register is empty or being taken.
// Reset clears both registers' valid bits, the header phase and counters.
// While res_stall holds, the result stays put, one more byte is held in the
// input register and rx_stall then rises.
`timescale 1ns / 1ps

module parity_frame_deframer (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      rx_valid,
  output logic                      rx_stall,
  input  logic [pfd_pkg::BYTE_W-1:0] rx_byte,
  output logic                      res_valid,
  input  logic                      res_stall,
  output logic                      has_data,
  output logic [pfd_pkg::CHAR_W-1:0] data_char,
  output logic                      parity_error,
  output logic [pfd_pkg::CNT_W-1:0] byte_offset,
  output logic                      stream_end,
  output logic [pfd_pkg::CNT_W-1:0] error_total
);
  import pfd_pkg::*;

  typedef enum logic [1:0] {
    HDR0,
    HDR1,
    HDR_LEN,
    PAYLOAD
  } phase_t;

  phase_t             phase;
  phase_t             phase_next;
  logic [LEN_W-1:0]   bytes_left;
  logic [LEN_W-1:0]   bytes_left_next;
  logic               short_frame;
  logic               short_frame_next;
  logic [CNT_W-1:0]   offset_count;
  logic [CNT_W-1:0]   offset_count_next;
  logic [CNT_W-1:0]   error_count;
  logic [CNT_W-1:0]   error_count_next;

  logic               in_valid;
  logic [BYTE_W-1:0]  in_byte;
  logic               advance;

  logic               produce;
  logic               r_has_data;
  logic [CHAR_W-1:0]  r_char;
  logic               r_err;
  logic [CNT_W-1:0]   r_offset;
  logic               r_end;
  logic [CNT_W-1:0]   r_total;

  logic [LEN_W-1:0]   len;
  logic               err;
  logic [CNT_W-1:0]   err_inc;
  logic [LEN_W-1:0]   left_dec;
  logic               last_byte;

  assign advance  = in_valid && (!res_valid || !res_stall);
  assign rx_stall = in_valid && !advance;

  // clamp length to FRAME_BYTES; bytes above 64 exceed the frame size
  assign len = (in_byte > BYTE_W'(FRAME_BYTES)) ? FRAME_LEN : in_byte[LEN_W-1:0];

  assign err       = ~^in_byte;
  assign err_inc   = (err && error_count != CNT_MAX) ? error_count + 1'b1 : error_count;
  assign left_dec  = (bytes_left != '0) ? bytes_left - 1'b1 : bytes_left;
  assign last_byte = (left_dec == '0);

  always_comb begin
    phase_next        = phase;
    bytes_left_next   = bytes_left;
    short_frame_next  = short_frame;
    offset_count_next = offset_count;
    error_count_next  = error_count;
    produce           = 1'b0;
    r_has_data        = 1'b0;
    r_char            = '0;
    r_err             = 1'b0;
    r_offset          = '0;
    r_end             = 1'b0;
    r_total           = error_count;
    unique case (phase)
      HDR0: phase_next = HDR1;
      HDR1: phase_next = HDR_LEN;
      HDR_LEN: begin
        if (len == '0) begin
          // empty frame closes the stream on its own
          produce           = 1'b1;
          r_end             = 1'b1;
          phase_next        = HDR0;
          bytes_left_next   = '0;
          short_frame_next  = 1'b0;
          offset_count_next = '0;
          error_count_next  = '0;
        end else begin
          bytes_left_next  = len;
          short_frame_next = (len < FRAME_LEN);
          phase_next       = PAYLOAD;
        end
      end
      PAYLOAD: begin
        produce           = 1'b1;
        r_has_data        = 1'b1;
        r_char            = in_byte[CHAR_W-1:0];
        r_err             = err;
        r_offset          = offset_count;
        r_end             = last_byte && short_frame;
        r_total           = err_inc;
        bytes_left_next   = left_dec;
        error_count_next  = err_inc;
        offset_count_next = offset_count + 1'b1;
        if (last_byte) begin
          phase_next = HDR0;
          if (short_frame) begin
            short_frame_next  = 1'b0;
            offset_count_next = '0;
            error_count_next  = '0;
          end
        end
      end
      default: phase_next = HDR0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid     <= 1'b0;
      res_valid    <= 1'b0;
      phase        <= HDR0;
      bytes_left   <= '0;
      short_frame  <= 1'b0;
      offset_count <= '0;
      error_count  <= '0;
    end else begin
      if (rx_valid && !rx_stall) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance && produce) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      if (advance) begin
        phase        <= phase_next;
        bytes_left   <= bytes_left_next;
        short_frame  <= short_frame_next;
        offset_count <= offset_count_next;
        error_count  <= error_count_next;
      end
    end
    // payload registers
    if (rx_valid && !rx_stall) begin
      in_byte <= rx_byte;
    end
    if (advance && produce) begin
      has_data     <= r_has_data;
      data_char    <= r_char;
      parity_error <= r_err;
      byte_offset  <= r_offset;
      stream_end   <= r_end;
      error_total  <= r_total;
    end
  end

endmodule

// File: hw/rtl/pfd_checker.sv
// port level checks for the parity frame deframer, bound to the top level
`timescale 1ns / 1ps

module pfd_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      res_valid,
  input logic                      res_stall,
  input logic                      has_data,
  input logic [pfd_pkg::CHAR_W-1:0] data_char,
  input logic                      parity_error,
  input logic [pfd_pkg::CNT_W-1:0] byte_offset,
  input logic                      stream_end,
  input logic [pfd_pkg::CNT_W-1:0] error_total
);
  import pfd_pkg::*;

  logic             res_xfer;
  logic             fresh;
  logic [CNT_W-1:0] last_total;

  assign res_xfer = res_valid && !res_stall;

  // fresh: the next result starts a new stream
  always_ff @(posedge clk) begin
    if (rst) begin
      fresh      <= 1'b1;
      last_total <= '0;
    end else if (res_xfer) begin
      fresh      <= stream_end;
      last_total <= stream_end ? '0 : error_total;
    end
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(data_char) && $stable(byte_offset)
      && $stable(error_total) && $stable(stream_end))
    else $error("stalled result changed");

  a_empty_frame: assert property (@(posedge clk) disable iff (rst)
    res_valid && !has_data |-> stream_end && data_char == '0 && !parity_error
      && byte_offset == '0)
    else $error("result without data is not a clean stream end");

  a_stream_start: assert property (@(posedge clk) disable iff (rst)
    res_valid && fresh && has_data |-> byte_offset == '0
      && error_total == CNT_W'(parity_error))
    else $error("stream did not restart its counters");

  a_total_step: assert property (@(posedge clk) disable iff (rst)
    res_valid && has_data |-> error_total == last_total
      || (error_total == last_total + 1'b1 && parity_error))
    else $error("error total stepped wrongly");

endmodule

bind parity_frame_deframer pfd_checker u_pfd_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (res_valid),
  .res_stall    (res_stall),
  .has_data     (has_data),
  .data_char    (data_char),
  .parity_error (parity_error),
  .byte_offset  (byte_offset),
  .stream_end   (stream_end),
  .error_total  (error_total)
);

// File: dv/tb_parity_frame_deframer.sv
// testbench for the parity frame deframer: directed and random framed byte streams checked against a predictor
`timescale 1ns / 1ps

module tb_parity_frame_deframer;
  import pfd_pkg::*;

  typedef enum logic [1:0] {HDR_FIRST, HDR_SECOND, HDR_LEN, PAYLOAD} frame_phase_t;

  typedef struct packed {
    logic              has_data;
    logic [CHAR_W-1:0] data_char;
    logic              parity_error;
    logic [CNT_W-1:0]  byte_offset;
    logic              stream_end;
    logic [CNT_W-1:0]  error_total;
  } char_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              rx_valid = 1'b0;
  logic              rx_stall;
  logic [BYTE_W-1:0] rx_byte = '0;
  logic              res_valid;
  logic              res_stall = 1'b0;
  logic              has_data;
  logic [CHAR_W-1:0] data_char;
  logic              parity_error;
  logic [CNT_W-1:0]  byte_offset;
  logic              stream_end;
  logic [CNT_W-1:0]  error_total;

  parity_frame_deframer uut (
    .clk          (clk),
    .rst          (rst),
    .rx_valid     (rx_valid),
    .rx_stall     (rx_stall),
    .rx_byte      (rx_byte),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .has_data     (has_data),
    .data_char    (data_char),
    .parity_error (parity_error),
    .byte_offset  (byte_offset),
    .stream_end   (stream_end),
    .error_total  (error_total)
  );

  always #6 clk = ~clk;

  // predictor state
  frame_phase_t     frame_phase = HDR_FIRST;
  logic [LEN_W-1:0] bytes_left = '0;
  logic             short_frame = 1'b0;
  logic [CNT_W-1:0] offset_count = '0;
  logic [CNT_W-1:0] error_count = '0;

  logic [BYTE_W-1:0] rx_pending[$];
  char_result_t      char_expect[$];
  int                mismatches = 0;

  bit rx_took = 1'b0;
  bit res_took = 1'b0;
  int rx_gap = 0;
  int res_hold = 0;
  bit rx_calm = 1'b0;
  bit res_calm = 1'b0;

  function automatic int draw_wait(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    if (calm || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 18);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // advance the frame parser by one byte, queueing any result it causes
  task automatic deframe_byte(input logic [BYTE_W-1:0] b);
    int           len;
    logic         err;
    logic         fin;
    char_result_t r;
    case (frame_phase)
      HDR_FIRST:  frame_phase = HDR_SECOND;
      HDR_SECOND: frame_phase = HDR_LEN;
      HDR_LEN: begin
        len = (b > FRAME_BYTES) ? FRAME_BYTES : int'(b);
        short_frame = (len < FRAME_BYTES);
        if (len == 0) begin
          // empty frame closes the stream at once
          r = '{has_data: 1'b0, data_char: '0, parity_error: 1'b0, byte_offset: '0,
                stream_end: 1'b1, error_total: error_count};
          char_expect.push_back(r);
          frame_phase = HDR_FIRST;
          bytes_left = '0;
          short_frame = 1'b0;
          offset_count = '0;
          error_count = '0;
        end else begin
          bytes_left = LEN_W'(len);
          frame_phase = PAYLOAD;
        end
      end
      default: begin
        err = ~^b;
        if (err && error_count != CNT_MAX) error_count++;
        if (bytes_left != 0) bytes_left--;
        fin = (bytes_left == 0) && short_frame;
        r = '{has_data: 1'b1, data_char: b[CHAR_W-1:0], parity_error: err,
              byte_offset: offset_count, stream_end: fin, error_total: error_count};
        char_expect.push_back(r);
        offset_count++;
        if (bytes_left == 0) begin
          frame_phase = HDR_FIRST;
          if (fin) begin
            short_frame = 1'b0;
            offset_count = '0;
            error_count = '0;
          end
        end
      end
    endcase
  endtask

  task automatic queue_frame(input logic [BYTE_W-1:0] len_byte);
    int n;
    n = (len_byte > FRAME_BYTES) ? FRAME_BYTES : int'(len_byte);
    rx_pending.push_back(BYTE_W'($urandom_range(0, 255)));
    rx_pending.push_back(BYTE_W'($urandom_range(0, 255)));
    rx_pending.push_back(len_byte);
    repeat (n) rx_pending.push_back(BYTE_W'($urandom_range(0, 255)));
  endtask

  // monitor and predictor feed
  always @(posedge clk) begin
    char_result_t want;
    rx_took <= !rst && rx_valid && !rx_stall;
    res_took <= !rst && res_valid && !res_stall;
    if (!rst && res_valid && !res_stall) begin
      if (char_expect.size() == 0) begin
        report_mismatch("unexpected result", 32'({has_data, stream_end}), '0);
      end else begin
        want = char_expect.pop_front();
        if (has_data !== want.has_data)
          report_mismatch("has_data", 32'(has_data), 32'(want.has_data));
        if (data_char !== want.data_char)
          report_mismatch("data_char", 32'(data_char), 32'(want.data_char));
        if (parity_error !== want.parity_error)
          report_mismatch("parity_error", 32'(parity_error), 32'(want.parity_error));
        if (byte_offset !== want.byte_offset)
          report_mismatch("byte_offset", 32'(byte_offset), 32'(want.byte_offset));
        if (stream_end !== want.stream_end)
          report_mismatch("stream_end", 32'(stream_end), 32'(want.stream_end));
        if (error_total !== want.error_total)
          report_mismatch("error_total", 32'(error_total), 32'(want.error_total));
      end
    end
    if (!rst && rx_valid && !rx_stall) deframe_byte(rx_byte);
  end

  // byte driver
  always @(negedge clk) begin
    if (!rst) begin
      if (rx_valid && !rx_took) begin
        // stalled transfer, hold payload
      end else if (rx_gap > 0) begin
        rx_valid <= 1'b0;
        rx_gap--;
      end else if (rx_pending.size() != 0) begin
        rx_byte <= rx_pending.pop_front();
        rx_valid <= 1'b1;
        rx_gap = draw_wait(rx_calm);
      end else begin
        rx_valid <= 1'b0;
      end
    end
  end

  // result side backpressure
  always @(negedge clk) begin
    if (!rst) begin
      if (res_took) res_hold = draw_wait(res_calm);
      if (res_hold > 0) begin
        res_stall <= 1'b1;
        res_hold--;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  initial begin
    int r;
    // empty frame, header byte extremes
    rx_pending = '{8'h00, 8'hff, 8'h00};
    // one byte of even parity ends the stream with an error
    rx_pending.push_back(8'hff); rx_pending.push_back(8'h00); rx_pending.push_back(8'h01);
    rx_pending.push_back(8'h00);
    rx_pending.push_back(8'h55); rx_pending.push_back(8'haa); rx_pending.push_back(8'h02);
    rx_pending.push_back(8'hff); rx_pending.push_back(8'h80);
    rx_pending.push_back(8'h01); rx_pending.push_back(8'h02); rx_pending.push_back(8'h03);
    rx_pending.push_back(8'h01); rx_pending.push_back(8'h7f); rx_pending.push_back(8'hfe);

    while (rx_pending.size() < 650) begin
      r = $urandom_range(0, 99);
      if (r < 12) queue_frame(8'h00);
      else if (r < 22) queue_frame(BYTE_W'(FRAME_BYTES));
      else if (r < 30) queue_frame(BYTE_W'($urandom_range(FRAME_BYTES + 1, 255)));
      else if (r < 90) queue_frame(BYTE_W'($urandom_range(1, 12)));
      else queue_frame(BYTE_W'($urandom_range(13, FRAME_BYTES - 1)));
    end
    queue_frame(8'h01);

    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (rx_pending.size() != 0 || rx_valid) @(posedge clk);
    while (char_expect.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatches == 0 && char_expect.size() == 0) begin
      $display("tb_parity_frame_deframer OK");
    end else begin
      $display("tb_parity_frame_deframer NOT OK");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb_parity_frame_deframer NOT OK");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/pfd_pkg.sv
hw/rtl/parity_frame_deframer.sv
hw/rtl/pfd_checker.sv
dv/tb_parity_frame_deframer.sv
